FILE: sv/sliding_mode_back_emf_observer_defines.svh
// Assertion macros used by the port-level checker of the back-EMF observer.
`ifndef SLIDING_MODE_BACK_EMF_OBSERVER_DEFINES_SVH
`define SLIDING_MODE_BACK_EMF_OBSERVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SMO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("observer assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SMO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("observer assertion failed");

`endif

FILE: sv/smo_pkg.sv
// Shared types and constants of the sliding-mode back-EMF observer.
`default_nettype none

package smo_pkg;

    localparam int COEF_FRAC = 16;
    localparam int COEF_W    = 18;
    localparam int KF_W      = 17;
    localparam int CFG_W     = 31;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] REG_MODEL_DECAY  = 3'd0;
    localparam logic [IDX_W-1:0] REG_MODEL_GAIN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SLIDING_GAIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_FILTER_GAIN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_ERROR_LIMIT  = 3'd4;

    localparam logic [COEF_W-1:0] DECAY_RESET  = 18'd62967;
    localparam logic [COEF_W-1:0] GAIN_RESET   = 18'd0;
    localparam logic [COEF_W-1:0] SLIDE_RESET  = 18'd11141;
    localparam logic [KF_W-1:0]   FILTER_RESET = 17'd3932;
    localparam logic [KF_W-1:0]   KF_ONE       = 17'd65536;

    // Operation of one multiply pass
    typedef enum logic [1:0] {
        OP_DECAY  = 2'd0,   // acc = cur * F
        OP_DRIVE  = 2'd1,   // cur = sat(acc + (V - E - Z) * G)
        OP_SLIDE  = 2'd2,   // Z = sat(clamp(cur - I) * K)
        OP_FILTER = 2'd3    // E = sat(E + (Z - E) * Kf)
    } op_t;

    typedef enum logic {
        AX_ALPHA = 1'b0,
        AX_BETA  = 1'b1
    } axis_t;

    // Controller to datapath command
    typedef struct packed {
        logic  load;      // capture the input transaction
        logic  issue;     // start a multiply pass
        op_t   op;
        axis_t axis;
        logic  out_load;  // copy the state into the output register
    } cmd_t;

endpackage

`default_nettype wire

FILE: sv/smo_if.sv
// Stream interfaces for observer samples and results.
`default_nettype none

interface smo_in_if #(parameter int SW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] volt_alpha;
    logic signed [SW-1:0] volt_beta;
    logic signed [SW-1:0] amp_alpha;
    logic signed [SW-1:0] amp_beta;

    modport source (output valid, volt_alpha, volt_beta, amp_alpha, amp_beta, input ready);
    modport sink   (input valid, volt_alpha, volt_beta, amp_alpha, amp_beta, output ready);
endinterface

interface smo_out_if #(parameter int SW = 32);
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] emf_alpha;
    logic signed [SW-1:0] emf_beta;
    logic signed [SW-1:0] est_amp_alpha;
    logic signed [SW-1:0] est_amp_beta;

    modport source (output valid, emf_alpha, emf_beta, est_amp_alpha, est_amp_beta,
                    input ready);
    modport sink   (input valid, emf_alpha, emf_beta, est_amp_alpha, est_amp_beta,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/smo_ctrl.sv
// Sequencer of the observer: handshakes and the multiply schedule.
`default_nettype none

module smo_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output smo_pkg::cmd_t      cmd
);
    import smo_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    localparam logic [3:0] LAST_STEP = 4'd11;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       issue;
    op_t        op;
    axis_t      axis;

    // Two axes interleave; a dependent pass waits for the write-back of the pass it needs.
    always_comb
    begin
        issue = 1'b1;
        op    = OP_DECAY;
        axis  = AX_ALPHA;
        unique case (step_reg)
            4'd0:    begin op = OP_DECAY;  axis = AX_ALPHA; end
            4'd1:    begin op = OP_DECAY;  axis = AX_BETA;  end
            4'd2:    begin op = OP_DRIVE;  axis = AX_ALPHA; end
            4'd3:    begin op = OP_DRIVE;  axis = AX_BETA;  end
            4'd5:    begin op = OP_SLIDE;  axis = AX_ALPHA; end
            4'd6:    begin op = OP_SLIDE;  axis = AX_BETA;  end
            4'd8:    begin op = OP_FILTER; axis = AX_ALPHA; end
            4'd9:    begin op = OP_FILTER; axis = AX_BETA;  end
            default: issue = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = op;
        cmd.axis       = axis;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = issue;
                step_next = step_reg + 4'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: sv/smo_datapath.sv
// Observer datapath: config registers, shared multiplier, axis state, output register.
`default_nettype none

module smo_datapath #(
    parameter int SW        = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire smo_pkg::cmd_t              cmd,
    input  wire logic                       cfg_we,
    input  wire logic [smo_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [smo_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic signed [SW-1:0]       volt_alpha,
    input  wire logic signed [SW-1:0]       volt_beta,
    input  wire logic signed [SW-1:0]       amp_alpha,
    input  wire logic signed [SW-1:0]       amp_beta,
    output logic signed [SW-1:0]            emf_alpha,
    output logic signed [SW-1:0]            emf_beta,
    output logic signed [SW-1:0]            est_amp_alpha,
    output logic signed [SW-1:0]            est_amp_beta
);
    import smo_pkg::*;

    // Operand holds V - E - Z and the clamped error (limit up to 2^31 - 1)
    localparam int OW     = (SW + 2 > CFG_W + 2) ? SW + 2 : CFG_W + 2;
    localparam int PROD_W = OW + COEF_W + 1;
    localparam int PW     = PROD_W - COEF_FRAC;
    localparam int SUM_W  = PW + 1;

    localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(4) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SMAX = {{(SUM_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = {{(SUM_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

    function automatic logic signed [SW-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [SW-1:0] r;
        if (v > SMAX)
            r = SMAX[SW-1:0];
        else if (v < SMIN)
            r = SMIN[SW-1:0];
        else
            r = v[SW-1:0];
        return r;
    endfunction

    // Configuration
    logic [COEF_W-1:0] decay_reg, gain_reg, sgain_reg;
    logic [KF_W-1:0]   fgain_reg;
    logic [CFG_W-1:0]  limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= DECAY_RESET;
            gain_reg  <= GAIN_RESET;
            sgain_reg <= SLIDE_RESET;
            fgain_reg <= FILTER_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODEL_DECAY:  decay_reg <= cfg_data[COEF_W-1:0];
                REG_MODEL_GAIN:   gain_reg  <= cfg_data[COEF_W-1:0];
                REG_SLIDING_GAIN: sgain_reg <= cfg_data[COEF_W-1:0];
                REG_FILTER_GAIN:  fgain_reg <= cfg_data[KF_W-1:0];
                REG_ERROR_LIMIT:  limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Captured sample
    logic signed [SW-1:0] volt_a_reg, volt_b_reg, amp_a_reg, amp_b_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            volt_a_reg <= volt_alpha;
            volt_b_reg <= volt_beta;
            amp_a_reg  <= amp_alpha;
            amp_b_reg  <= amp_beta;
        end
    end

    // Axis state
    logic signed [SW-1:0] cur_a_reg, cur_b_reg, slide_a_reg, slide_b_reg;
    logic signed [SW-1:0] emf_a_reg, emf_b_reg;
    logic signed [PW-1:0] acc_a_reg, acc_b_reg;

    // Operand stage
    logic signed [SW-1:0] op_cur, op_slide, op_emf, op_volt, op_amp;
    logic signed [OW-1:0] diff, lim, opnd;
    logic [COEF_W-1:0]    coef;
    logic signed [OW-1:0] opnd_reg;
    logic [COEF_W-1:0]    coef_reg;
    logic                 t1_valid_reg;
    op_t                  t1_op_reg;
    axis_t                t1_axis_reg;

    assign op_cur   = (cmd.axis == AX_BETA) ? cur_b_reg   : cur_a_reg;
    assign op_slide = (cmd.axis == AX_BETA) ? slide_b_reg : slide_a_reg;
    assign op_emf   = (cmd.axis == AX_BETA) ? emf_b_reg   : emf_a_reg;
    assign op_volt  = (cmd.axis == AX_BETA) ? volt_b_reg  : volt_a_reg;
    assign op_amp   = (cmd.axis == AX_BETA) ? amp_b_reg   : amp_a_reg;
    assign lim      = $signed(OW'(limit_reg));
    assign diff     = OW'(op_cur) - OW'(op_amp);

    always_comb
    begin
        unique case (cmd.op)
            OP_DECAY:
            begin
                opnd = OW'(op_cur);
                coef = decay_reg;
            end
            OP_DRIVE:
            begin
                opnd = OW'(op_volt) - OW'(op_emf) - OW'(op_slide);
                coef = gain_reg;
            end
            OP_SLIDE:
            begin
                if (diff > lim)
                    opnd = lim;
                else if (diff < -lim)
                    opnd = -lim;
                else
                    opnd = diff;
                coef = sgain_reg;
            end
            OP_FILTER:
            begin
                opnd = OW'(op_slide) - OW'(op_emf);
                coef = (fgain_reg > KF_ONE) ? COEF_W'(KF_ONE) : COEF_W'(fgain_reg);
            end
            default:
            begin
                opnd = '0;
                coef = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            opnd_reg    <= opnd;
            coef_reg    <= coef;
            t1_op_reg   <= cmd.op;
            t1_axis_reg <= cmd.axis;
        end
    end

    // Multiply stage: floor of product / 2^16
    logic signed [PROD_W-1:0] prod_full;
    logic signed [PW-1:0]     prod_reg;
    logic                     t2_valid_reg;
    op_t                      t2_op_reg;
    axis_t                    t2_axis_reg;

    assign prod_full = opnd_reg * $signed({1'b0, coef_reg});

    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_full[PROD_W-1:COEF_FRAC];
        t2_op_reg   <= t1_op_reg;
        t2_axis_reg <= t1_axis_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
        end
        else
        begin
            t1_valid_reg <= cmd.issue;
            t2_valid_reg <= t1_valid_reg;
        end
    end

    // Write-back stage
    logic signed [PW-1:0]    wb_acc;
    logic signed [SW-1:0]    wb_emf;
    logic signed [SUM_W-1:0] wb_sum;
    logic signed [SW-1:0]    wb_val;

    assign wb_acc = (t2_axis_reg == AX_BETA) ? acc_b_reg : acc_a_reg;
    assign wb_emf = (t2_axis_reg == AX_BETA) ? emf_b_reg : emf_a_reg;

    always_comb
    begin
        unique case (t2_op_reg)
            OP_DRIVE:  wb_sum = SUM_W'(wb_acc) + SUM_W'(prod_reg);
            OP_FILTER: wb_sum = SUM_W'(wb_emf) + SUM_W'(prod_reg);
            default:   wb_sum = SUM_W'(prod_reg);
        endcase
        wb_val = sat(wb_sum);
    end

    always_ff @(posedge clk)
    begin
        if (t2_valid_reg && t2_op_reg == OP_DECAY)
        begin
            if (t2_axis_reg == AX_BETA)
                acc_b_reg <= prod_reg;
            else
                acc_a_reg <= prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_a_reg   <= '0;
            cur_b_reg   <= '0;
            slide_a_reg <= '0;
            slide_b_reg <= '0;
            emf_a_reg   <= '0;
            emf_b_reg   <= '0;
        end
        else if (t2_valid_reg)
        begin
            unique case (t2_op_reg)
                OP_DRIVE:
                begin
                    if (t2_axis_reg == AX_BETA)
                        cur_b_reg <= wb_val;
                    else
                        cur_a_reg <= wb_val;
                end
                OP_SLIDE:
                begin
                    if (t2_axis_reg == AX_BETA)
                        slide_b_reg <= wb_val;
                    else
                        slide_a_reg <= wb_val;
                end
                OP_FILTER:
                begin
                    if (t2_axis_reg == AX_BETA)
                        emf_b_reg <= wb_val;
                    else
                        emf_a_reg <= wb_val;
                end
                default: ;
            endcase
        end
    end

    // Output register
    logic signed [SW-1:0] out_emf_a_reg, out_emf_b_reg, out_cur_a_reg, out_cur_b_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_emf_a_reg <= emf_a_reg;
            out_emf_b_reg <= emf_b_reg;
            out_cur_a_reg <= cur_a_reg;
            out_cur_b_reg <= cur_b_reg;
        end
    end

    assign emf_alpha     = out_emf_a_reg;
    assign emf_beta      = out_emf_b_reg;
    assign est_amp_alpha = out_cur_a_reg;
    assign est_amp_beta  = out_cur_b_reg;

endmodule

`default_nettype wire

FILE: sv/sliding_mode_back_emf_observer.sv
// Sliding-mode back-EMF observer top level: sequencer plus datapath.
//
// Usage:
//  - sample channel carries the alpha/beta stator voltages and measured currents
//    (signed, FRAC_BITS fractional bits). result channel returns the filtered
//    back-EMF and the model currents of both axes after the update.
//  - Coefficients are written through cfg_we/cfg_index/cfg_data while idle;
//    indexes 0..4 are decay, gain, sliding gain, filter gain, error limit.
//  - One sample is processed at a time. Each needs eight passes through the one
//    shared signal-by-coefficient multiplier (three-stage operand/multiply/
//    write-back pipe, both axes interleaved); the next sample is taken the cycle
//    after the result is loaded.
//  - The output register holds a finished result while the receiver stalls; the
//    next sample is taken and computed meanwhile and waits in its finish state
//    until the output register frees.
//  - Reset clears the observer state, result valid, and loads the default
//    coefficients (error limit 4.0). No clearing pass is needed.
`default_nettype none

module sliding_mode_back_emf_observer #(
    parameter int SIGNAL_WIDTH = 32,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    smo_in_if.sink                          sample,
    smo_out_if.source                       result,
    input  wire logic                       cfg_we,
    input  wire logic [smo_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [smo_pkg::CFG_W-1:0]  cfg_data
);
    import smo_pkg::*;

    cmd_t cmd;

    smo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    smo_datapath #(
        .SW        (SIGNAL_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .volt_alpha    (sample.volt_alpha),
        .volt_beta     (sample.volt_beta),
        .amp_alpha     (sample.amp_alpha),
        .amp_beta      (sample.amp_beta),
        .emf_alpha     (result.emf_alpha),
        .emf_beta      (result.emf_beta),
        .est_amp_alpha (result.est_amp_alpha),
        .est_amp_beta  (result.est_amp_beta)
    );

endmodule

`default_nettype wire

FILE: sv/smo_checker.sv
// Port-level checks of the observer, bound to the top level.
`default_nettype none
`include "sliding_mode_back_emf_observer_defines.svh"

module smo_checker #(
    parameter int SW = 32
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic signed [SW-1:0] out_emf_alpha,
    input wire logic signed [SW-1:0] out_est_amp_beta
);
    logic in_xact;
    logic out_stall;

    assign in_xact   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    `SMO_ASSERT_NEXT(a_out_valid_holds, out_stall, out_valid)
    `SMO_ASSERT_NEXT(a_out_data_holds, out_stall, $stable(out_emf_alpha) && $stable(out_est_amp_beta))
    // one sample in flight: no second sample right after one is taken
    `SMO_ASSERT_NEXT(a_one_in_flight, in_xact, !in_ready)
    // the multiply schedule takes many cycles: no result appears right away
    `SMO_ASSERT_NEXT(a_no_fast_result, in_xact, !$rose(out_valid))

endmodule

bind sliding_mode_back_emf_observer smo_checker #(.SW(SIGNAL_WIDTH)) u_smo_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (sample.valid),
    .in_ready         (sample.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_emf_alpha    (result.emf_alpha),
    .out_est_amp_beta (result.est_amp_beta)
);

`default_nettype wire

FILE: sim/sliding_mode_back_emf_observer_test.sv
// Self-checking testbench for the sliding-mode back-EMF observer.
`default_nettype none

module sliding_mode_back_emf_observer_test;

    import smo_pkg::*;

    localparam int SW             = 32;
    localparam int FRAC           = 16;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ROUNDS  = 4;
    localparam int ROUND_ITEMS    = 117;

    localparam longint SIG_MAX = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SIG_MIN = -SIG_MAX - 1;

    localparam logic signed [SW-1:0] FIELD_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] FIELD_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] UNIT      = 1 <<< FRAC;
    localparam logic [CFG_W-1:0]     LIMIT_RESET = CFG_W'(4) << FRAC;
    localparam logic [IDX_W-1:0]     REG_UNUSED_FIRST = REG_ERROR_LIMIT + 1'b1;

    typedef struct {
        logic signed [SW-1:0] emf_alpha;
        logic signed [SW-1:0] emf_beta;
        logic signed [SW-1:0] est_amp_alpha;
        logic signed [SW-1:0] est_amp_beta;
    } estimate_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    smo_in_if  #(.SW(SW)) sample_ch ();
    smo_out_if #(.SW(SW)) result_ch ();

    sliding_mode_back_emf_observer #(
        .SIGNAL_WIDTH (SW),
        .FRAC_BITS    (FRAC)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // observer shadow: coefficients and per-axis state
    logic [COEF_W-1:0] decay_q;
    logic [COEF_W-1:0] gain_q;
    logic [COEF_W-1:0] slide_gain_q;
    logic [KF_W-1:0]   kf_q;
    logic [CFG_W-1:0]  limit_q;
    longint            est_cur_a, est_cur_b;
    longint            slide_a, slide_b;
    longint            emf_a, emf_b;

    estimate_t pending_estimates[$];
    int        mismatch_count;
    int        result_count;
    int        src_idle_pct;
    int        dst_idle_pct;
    int        hold_requests;
    int        hold_served;
    int        hold_left;
    int        stalled_cycles;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint clip_signal(longint v);
        if (v > SIG_MAX)
            return SIG_MAX;
        if (v < SIG_MIN)
            return SIG_MIN;
        return v;
    endfunction

    // exact product, floored back to signal scale
    function automatic longint coef_mul(longint a, longint c);
        longint p;
        p = a * c;
        return p >>> COEF_FRAC;
    endfunction

    task automatic advance_axis(inout longint cur, inout longint slide, inout longint emf,
                                input longint volt, input longint amp);
        longint lim;
        longint kf;
        longint err;
        lim = limit_q;
        kf = (kf_q > KF_ONE) ? KF_ONE : kf_q;
        cur = clip_signal(coef_mul(cur, decay_q) + coef_mul(volt - emf - slide, gain_q));
        err = cur - amp;
        if (err > lim)
            err = lim;
        else if (err < -lim)
            err = -lim;
        slide = clip_signal(coef_mul(err, slide_gain_q));
        emf = clip_signal(emf + coef_mul(slide - emf, kf));
    endtask

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("result %0d: %s", result_count, msg);
    endtask

    task automatic compare_field(string field, logic [SW-1:0] got, logic [SW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", field, got, want));
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MODEL_DECAY:  decay_q      = data[COEF_W-1:0];
            REG_MODEL_GAIN:   gain_q       = data[COEF_W-1:0];
            REG_SLIDING_GAIN: slide_gain_q = data[COEF_W-1:0];
            REG_FILTER_GAIN:  kf_q         = data[KF_W-1:0];
            REG_ERROR_LIMIT:  limit_q      = data;
            default: ;
        endcase
    endtask

    task automatic set_idling(int src_pct, int dst_pct);
        src_idle_pct <= src_pct;
        dst_idle_pct <= dst_pct;
    endtask

    task automatic send_sample(logic signed [SW-1:0] va, logic signed [SW-1:0] vb,
                               logic signed [SW-1:0] ia, logic signed [SW-1:0] ib);
        estimate_t est;
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.volt_alpha <= va;
        sample_ch.volt_beta  <= vb;
        sample_ch.amp_alpha  <= ia;
        sample_ch.amp_beta   <= ib;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        advance_axis(est_cur_a, slide_a, emf_a, va, ia);
        advance_axis(est_cur_b, slide_b, emf_b, vb, ib);
        est.emf_alpha     = emf_a[SW-1:0];
        est.emf_beta      = emf_b[SW-1:0];
        est.est_amp_alpha = est_cur_a[SW-1:0];
        est.est_amp_beta  = est_cur_b[SW-1:0];
        pending_estimates.push_back(est);
    endtask

    // drop valid, let every estimate come back, then let the pipe go quiet
    task automatic settle_idle();
        sample_ch.valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SW-1:0] random_signal(int span);
        if ($urandom_range(9) < 3)
            return $urandom;
        return $urandom_range(2 * span) - span;
    endfunction

    task automatic send_random_sample();
        send_sample(random_signal(24 <<< FRAC), random_signal(24 <<< FRAC),
                    random_signal(8 <<< FRAC), random_signal(8 <<< FRAC));
    endtask

    // pick zero, the top value, a usual value or anything, upper bits junk
    function automatic logic [CFG_W-1:0] pick_coef(int top, int lo, int hi);
        logic [CFG_W-1:0] data;
        int               pick;
        data = CFG_W'($urandom);
        pick = $urandom_range(5);
        data[COEF_W-1:0] = COEF_W'((pick == 0) ? 0 :
                                   (pick == 1) ? top :
                                   (pick == 5) ? $urandom_range(top) :
                                   $urandom_range(hi, lo));
        return data;
    endfunction

    task automatic test_reset_defaults();
        set_idling(9, 66);
        send_sample(0, 0, 0, 0);
        send_sample(0, 0, FIELD_MAX, FIELD_MIN);
        send_sample(0, 0, FIELD_MIN, FIELD_MAX);
        send_sample(FIELD_MAX, FIELD_MIN, -1, -1);
        settle_idle();
    endtask

    task automatic test_field_extremes();
        write_reg(REG_MODEL_GAIN, 13107);
        send_sample(FIELD_MAX, FIELD_MIN, 0, 0);
        send_sample(FIELD_MIN, FIELD_MAX, 0, 0);
        send_sample(0, 0, FIELD_MAX, FIELD_MIN);
        send_sample(0, 0, FIELD_MIN, FIELD_MAX);
        send_sample(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
        send_sample(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN);
        send_sample(-1, -1, -1, -1);
        send_sample(0, 0, 0, 0);
        settle_idle();
    endtask

    task automatic test_special_cases();
        // filter gain above one acts as one
        write_reg(REG_FILTER_GAIN, {KF_W{1'b1}});
        send_sample(12 * UNIT, -12 * UNIT, UNIT, -UNIT);
        send_sample(-3 * UNIT, 5 * UNIT, -UNIT, UNIT);
        settle_idle();
        write_reg(REG_FILTER_GAIN, FILTER_RESET);

        // zero clamp kills the sliding term
        write_reg(REG_ERROR_LIMIT, 0);
        send_sample(20 * UNIT, -20 * UNIT, 2 * UNIT, -2 * UNIT);
        send_sample(FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX);
        settle_idle();

        // clamp at the top of the signal range, sliding term saturates
        write_reg(REG_ERROR_LIMIT, {CFG_W{1'b1}});
        write_reg(REG_SLIDING_GAIN, {COEF_W{1'b1}});
        send_sample(0, 0, FIELD_MIN, FIELD_MAX);
        send_sample(FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN);
        settle_idle();
        write_reg(REG_ERROR_LIMIT, LIMIT_RESET);
        write_reg(REG_SLIDING_GAIN, SLIDE_RESET);

        // writes past the last register change nothing
        for (int idx = REG_UNUSED_FIRST; idx < (1 << IDX_W); idx++)
            write_reg(idx[IDX_W-1:0], {CFG_W{1'b1}});
        send_sample(7 * UNIT, -7 * UNIT, UNIT, 0);
        send_sample(-7 * UNIT, 7 * UNIT, 0, -UNIT);
        settle_idle();

        // bits above each register width are dropped
        write_reg(REG_MODEL_DECAY, {{(CFG_W-COEF_W){1'b1}}, DECAY_RESET});
        write_reg(REG_MODEL_GAIN, {{(CFG_W-COEF_W){1'b1}}, 18'd13107});
        write_reg(REG_FILTER_GAIN, {{(CFG_W-KF_W){1'b1}}, FILTER_RESET});
        send_sample(10 * UNIT, 4 * UNIT, UNIT, UNIT);
        send_sample(-10 * UNIT, -4 * UNIT, -UNIT, -UNIT);
        settle_idle();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        hold_requests <= hold_requests + 1;
        repeat (12) send_random_sample();
        settle_idle();
    endtask

    task automatic test_random();
        logic [CFG_W-1:0] kf_data;
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0: set_idling(9, 66);
                1: set_idling(66, 9);
                default: set_idling(0, 0);
            endcase
            for (int round = 0; round < RANDOM_ROUNDS; round++)
            begin
                write_reg(REG_MODEL_DECAY, pick_coef((1 << COEF_W) - 1, 55000, 65536));
                write_reg(REG_MODEL_GAIN, pick_coef((1 << COEF_W) - 1, 1000, 20000));
                write_reg(REG_SLIDING_GAIN, pick_coef((1 << COEF_W) - 1, 5000, 30000));
                kf_data = CFG_W'($urandom);
                case ($urandom_range(4))
                    0: kf_data[KF_W-1:0] = 0;
                    1: kf_data[KF_W-1:0] = KF_ONE;
                    2: kf_data[KF_W-1:0] = KF_W'($urandom_range((1 << KF_W) - 1, KF_ONE + 1));
                    default: kf_data[KF_W-1:0] = KF_W'($urandom_range(KF_ONE));
                endcase
                write_reg(REG_FILTER_GAIN, kf_data);
                case ($urandom_range(4))
                    0: write_reg(REG_ERROR_LIMIT, 0);
                    1: write_reg(REG_ERROR_LIMIT, {CFG_W{1'b1}});
                    2: write_reg(REG_ERROR_LIMIT, CFG_W'($urandom));
                    default: write_reg(REG_ERROR_LIMIT,
                                       CFG_W'($urandom_range(16 << FRAC, 1 << FRAC)));
                endcase
                repeat (ROUND_ITEMS) send_random_sample();
                settle_idle();
            end
        end
    endtask

    // result side: checks each transaction, drives ready, serves hold requests
    always @(posedge clk)
    begin
        estimate_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_estimates.size() == 0)
            begin
                report_mismatch("no estimate pending");
            end
            else
            begin
                want = pending_estimates.pop_front();
                compare_field("emf_alpha", result_ch.emf_alpha, want.emf_alpha);
                compare_field("emf_beta", result_ch.emf_beta, want.emf_beta);
                compare_field("est_amp_alpha", result_ch.est_amp_alpha, want.est_amp_alpha);
                compare_field("est_amp_beta", result_ch.est_amp_beta, want.est_amp_beta);
            end
            result_count++;
        end
        if (!rst_n)
        begin
            hold_served    = 0;
            hold_left      = 0;
            mismatch_count = 0;
            result_count   = 0;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_served + 1;
            hold_left = HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            stalled_cycles <= 0;
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sliding_mode_back_emf_observer: mismatch");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_MODEL_DECAY;
        cfg_data             <= '0;
        sample_ch.valid      <= 1'b0;
        sample_ch.volt_alpha <= '0;
        sample_ch.volt_beta  <= '0;
        sample_ch.amp_alpha  <= '0;
        sample_ch.amp_beta   <= '0;
        src_idle_pct         <= 0;
        dst_idle_pct         <= 0;
        hold_requests        <= 0;
        decay_q        = DECAY_RESET;
        gain_q         = GAIN_RESET;
        slide_gain_q   = SLIDE_RESET;
        kf_q           = FILTER_RESET;
        limit_q        = LIMIT_RESET;
        est_cur_a      = 0;
        est_cur_b      = 0;
        slide_a        = 0;
        slide_b        = 0;
        emf_a          = 0;
        emf_b          = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_special_cases();
        test_backpressure();
        test_random();

        if (mismatch_count == 0)
            $display("sliding_mode_back_emf_observer: match");
        else
            $display("sliding_mode_back_emf_observer: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sliding_mode_back_emf_observer.f
+incdir+sv
sv/smo_pkg.sv
sv/smo_if.sv
sv/smo_ctrl.sv
sv/smo_datapath.sv
sv/sliding_mode_back_emf_observer.sv
sv/smo_checker.sv
sim/sliding_mode_back_emf_observer_test.sv
